[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge
`define BPMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define BPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bpms_pkg.sv]
// ----------------------------------------------------------------------------
// bpms_pkg
// Types and constants of the bottleneck path max spread unit.
// ----------------------------------------------------------------------------
package bpms_pkg;

  localparam int MaxVerticesDef = 1024;
  localparam int MaxEdgesDef    = 4096;
  localparam int WeightBitsDef  = 16;

  localparam logic [1:0] OpSetWeight = 2'd0;
  localparam logic [1:0] OpAddRoad   = 2'd1;
  localparam logic [1:0] OpCompute   = 2'd2;
  localparam logic [1:0] OpUnused    = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusBadIndex = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  vertex;
    logic [9:0]  other_vertex;
    logic        two_way;
    logic [15:0] weight;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] spread;
  } rsp_t;

  typedef enum logic [4:0] {
    StClrAll,
    StIdle,
    StExec,
    StRoad1,
    StRoad2,
    StRoad3,
    StRoad4,
    StClr,
    StInit,
    StInit2,
    StPop,
    StPop2,
    StPop3,
    StEdge,
    StEdge2,
    StEdge3,
    StAns,
    StAns2
  } state_e;

endpackage

[hdl/bottleneck_path_max_spread_unit.sv]
// ----------------------------------------------------------------------------
// bottleneck_path_max_spread_unit
// Graph store with a queue-based min/max relaxation and best spread search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_i when start is high and busy is low. Each request
//   gives one response on rsp_o, marked by done_o for exactly one cycle.
//   Set weight writes the weight directly; add road answers at once when
//   rejected, else reads the heads and writes the edge and the heads, once
//   for a one-way road and twice for a two-way road. Compute clears the
//   reached marks, then pops vertices and relaxes their edges for each of
//   the two walks, then runs the final spread search over the vertices;
//   every memory is single ported with a registered read.
//   vertex_count is written on the cfg channel, ready only while the unit
//   is idle. After reset the unit sweeps the adjacency heads and queue
//   marks with busy high before taking a request.
//   The receiver cannot stall: a response is shown once and taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bottleneck_path_max_spread_unit #(
  parameter int MaxVertices = bpms_pkg::MaxVerticesDef,
  parameter int MaxEdges    = bpms_pkg::MaxEdgesDef,
  parameter int WeightBits  = bpms_pkg::WeightBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bpms_pkg::req_t req_i,
  output logic           done_o,
  output bpms_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [9:0]     cfg_data_i
);
  import bpms_pkg::*;

  localparam int VB = $clog2(MaxVertices);
  localparam int HB = $clog2(MaxEdges + 1);
  localparam int EA = $clog2(MaxEdges);
  localparam int W  = WeightBits;

  state_e state_q, state_d;
  logic [9:0]    vc_q;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;
  logic          done_q, done_d;
  logic [VB-1:0] ix_q, ix_d, front_q, front_d, back_q, back_d, t_q, t_d, j_q, j_d;
  logic [HB-1:0] used_q, used_d, e_q, e_d;
  logic [W-1:0]  pt_q, pt_d, best_q, best_d;
  logic          dir_q, dir_d;

  // memories
  logic [W-1:0]        wt_mem [MaxVertices];
  logic [HB-1:0]       fh_mem [MaxVertices];
  logic [HB-1:0]       rh_mem [MaxVertices];
  logic [VB+HB-1:0]    fe_mem [MaxEdges];
  logic [VB+HB-1:0]    re_mem [MaxEdges];
  logic [W:0]          lo_mem [MaxVertices];
  logic [W:0]          hi_mem [MaxVertices];
  logic                qm_mem [MaxVertices];
  logic [VB-1:0]       rg_mem [MaxVertices];

  logic [VB-1:0]    wt_addr, fh_addr, rh_addr, lo_addr, hi_addr, qm_addr, rg_addr;
  logic [EA-1:0]    fe_addr, re_addr;
  logic             wt_we, fh_we, rh_we, fe_we, re_we, lo_we, hi_we, qm_we, rg_we;
  logic [W-1:0]     wt_wd, wt_rd;
  logic [HB-1:0]    fh_wd, rh_wd, fh_rd, rh_rd;
  logic [VB+HB-1:0] fe_wd, re_wd, fe_rd, re_rd;
  logic [W:0]       lo_wd, hi_wd, lo_rd, hi_rd;
  logic             qm_wd, qm_rd;
  logic [VB-1:0]    rg_wd, rg_rd;

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_addr] <= wt_wd;
    wt_rd <= wt_mem[wt_addr];
  end
  always_ff @(posedge clk_i) begin
    if (fh_we) fh_mem[fh_addr] <= fh_wd;
    fh_rd <= fh_mem[fh_addr];
  end
  always_ff @(posedge clk_i) begin
    if (rh_we) rh_mem[rh_addr] <= rh_wd;
    rh_rd <= rh_mem[rh_addr];
  end
  always_ff @(posedge clk_i) begin
    if (fe_we) fe_mem[fe_addr] <= fe_wd;
    fe_rd <= fe_mem[fe_addr];
  end
  always_ff @(posedge clk_i) begin
    if (re_we) re_mem[re_addr] <= re_wd;
    re_rd <= re_mem[re_addr];
  end
  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[lo_addr] <= lo_wd;
    lo_rd <= lo_mem[lo_addr];
  end
  always_ff @(posedge clk_i) begin
    if (hi_we) hi_mem[hi_addr] <= hi_wd;
    hi_rd <= hi_mem[hi_addr];
  end
  always_ff @(posedge clk_i) begin
    if (qm_we) qm_mem[qm_addr] <= qm_wd;
    qm_rd <= qm_mem[qm_addr];
  end
  always_ff @(posedge clk_i) begin
    if (rg_we) rg_mem[rg_addr] <= rg_wd;
    rg_rd <= rg_mem[rg_addr];
  end

  // decode helpers
  logic          a_ok, b_ok, vc_ok, accept, ring_empty, room, edge_end;
  logic [VB-1:0] a_idx, b_idx, vc_idx, start_idx, tgt;
  logic [HB-1:0] need, lnk;
  logic [W-1:0]  wj, pj, cand;
  logic          rj, better;
  logic [W:0]    pr_rd;

  assign accept     = start && !busy;
  assign a_ok       = (req_q.vertex != 10'd0) && (req_q.vertex <= vc_q) &&
                      (32'(req_q.vertex) < MaxVertices);
  assign b_ok       = (req_q.other_vertex != 10'd0) && (req_q.other_vertex <= vc_q) &&
                      (32'(req_q.other_vertex) < MaxVertices);
  assign vc_ok      = (vc_q != 10'd0) && (32'(vc_q) < MaxVertices);
  assign a_idx      = VB'(req_q.vertex);
  assign b_idx      = VB'(req_q.other_vertex);
  assign vc_idx     = VB'(vc_q);
  assign start_idx  = dir_q ? vc_idx : VB'(1);
  assign need       = req_q.two_way ? HB'(2) : HB'(1);
  assign room       = (HB'(MaxEdges) - used_q) >= need;
  assign ring_empty = (front_q == back_q);
  assign edge_end   = (e_q == '0) || (e_q > used_q);
  assign tgt        = dir_q ? re_rd[VB+HB-1:HB] : fe_rd[VB+HB-1:HB];
  assign lnk        = dir_q ? re_rd[HB-1:0] : fe_rd[HB-1:0];
  assign pr_rd      = dir_q ? hi_rd : lo_rd;
  assign wj         = wt_rd;
  assign pj         = pr_rd[W-1:0];
  assign rj         = pr_rd[W];
  assign cand       = dir_q ? ((pt_q > wj) ? pt_q : wj) : ((pt_q < wj) ? pt_q : wj);
  assign better     = !rj || (dir_q ? (pj < cand) : (pj > cand));

  function automatic logic [VB-1:0] ring_next(input logic [VB-1:0] x);
    return (32'(x) == MaxVertices - 1) ? '0 : x + VB'(1);
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClrAll: if (32'(ix_q) == MaxVertices - 1) state_d = StIdle;
      StIdle:   if (accept) state_d = StExec;
      StExec: begin
        state_d = StIdle;
        if (req_q.op == OpAddRoad && a_ok && b_ok && room) state_d = StRoad1;
        if (req_q.op == OpCompute && vc_ok) state_d = StClr;
      end
      StRoad1: state_d = StRoad2;
      StRoad2: state_d = req_q.two_way ? StRoad3 : StIdle;
      StRoad3: state_d = StRoad4;
      StRoad4: state_d = StIdle;
      StClr:   if (32'(ix_q) == MaxVertices - 1) state_d = StInit;
      StInit:  state_d = StInit2;
      StInit2: state_d = StPop;
      StPop: begin
        if (!ring_empty)  state_d = StPop2;
        else if (!dir_q)  state_d = StInit;
        else              state_d = StAns;
      end
      StPop2:  state_d = StPop3;
      StPop3:  state_d = StEdge;
      StEdge:  state_d = edge_end ? StPop : StEdge2;
      StEdge2: state_d = StEdge3;
      StEdge3: state_d = StEdge;
      StAns:   state_d = StAns2;
      StAns2:  state_d = (ix_q == vc_idx) ? StIdle : StAns;
      default: state_d = StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d = req_q; rsp_d = rsp_q; done_d = 1'b0;
    ix_d = ix_q; front_d = front_q; back_d = back_q; t_d = t_q; j_d = j_q;
    used_d = used_q; e_d = e_q; pt_d = pt_q; best_d = best_q; dir_d = dir_q;
    wt_addr = a_idx; wt_we = 1'b0; wt_wd = W'(req_q.weight);
    fh_addr = a_idx; fh_we = 1'b0; fh_wd = '0;
    rh_addr = b_idx; rh_we = 1'b0; rh_wd = '0;
    fe_addr = EA'(used_q); fe_we = 1'b0; fe_wd = {b_idx, fh_rd};
    re_addr = EA'(used_q); re_we = 1'b0; re_wd = {a_idx, rh_rd};
    lo_addr = ix_q; lo_we = 1'b0; lo_wd = '0;
    hi_addr = ix_q; hi_we = 1'b0; hi_wd = '0;
    qm_addr = ix_q; qm_we = 1'b0; qm_wd = 1'b0;
    rg_addr = front_q; rg_we = 1'b0; rg_wd = j_q;
    unique case (state_q)
      StClrAll: begin
        fh_addr = ix_q; fh_we = 1'b1;
        rh_addr = ix_q; rh_we = 1'b1;
        qm_we = 1'b1;
        ix_d = ix_q + VB'(1);
      end
      StIdle: if (accept) req_d = req_i;
      StExec: begin
        rsp_d = '{status: StatusOk, spread: 16'd0};
        done_d = 1'b1;
        case (req_q.op)
          OpSetWeight: begin
            if (a_ok) wt_we = 1'b1;
            else rsp_d.status = StatusBadIndex;
          end
          OpAddRoad: begin
            if (!a_ok || !b_ok) rsp_d.status = StatusBadIndex;
            else if (!room) rsp_d.status = StatusFull;
            else done_d = 1'b0;
          end
          OpCompute: begin
            if (!vc_ok) rsp_d.status = StatusBadIndex;
            else done_d = 1'b0;
          end
          default: ;
        endcase
        ix_d = '0; best_d = '0; dir_d = 1'b0;
      end
      StRoad2: begin
        fe_we = 1'b1; re_we = 1'b1;
        fh_we = 1'b1; fh_wd = used_q + HB'(1);
        rh_we = 1'b1; rh_wd = used_q + HB'(1);
        if (!req_q.two_way) begin
          used_d = used_q + HB'(1);
          done_d = 1'b1;
        end
      end
      StRoad3: begin
        fh_addr = b_idx; rh_addr = a_idx;
      end
      StRoad4: begin
        fh_addr = b_idx; rh_addr = a_idx;
        fe_addr = EA'(used_q + HB'(1)); re_addr = EA'(used_q + HB'(1));
        fe_wd = {a_idx, fh_rd}; re_wd = {b_idx, rh_rd};
        fe_we = 1'b1; re_we = 1'b1;
        fh_we = 1'b1; fh_wd = used_q + HB'(2);
        rh_we = 1'b1; rh_wd = used_q + HB'(2);
        used_d = used_q + HB'(2);
        done_d = 1'b1;
      end
      StClr: begin
        lo_we = 1'b1; hi_we = 1'b1;
        ix_d = ix_q + VB'(1);
      end
      StInit: begin
        wt_addr = start_idx;
        front_d = '0; back_d = '0;
      end
      StInit2: begin
        lo_addr = start_idx; hi_addr = start_idx;
        lo_wd = {1'b1, wt_rd}; hi_wd = {1'b1, wt_rd};
        lo_we = !dir_q; hi_we = dir_q;
        rg_addr = back_q; rg_wd = start_idx; rg_we = 1'b1;
        qm_addr = start_idx; qm_wd = 1'b1; qm_we = 1'b1;
        back_d = ring_next(back_q);
      end
      StPop: begin
        rg_addr = front_q;
        if (ring_empty) begin
          dir_d = 1'b1;
          ix_d = VB'(1);
        end
      end
      StPop2: begin
        t_d = rg_rd;
        front_d = ring_next(front_q);
        qm_addr = rg_rd; qm_we = 1'b1;
        fh_addr = rg_rd; rh_addr = rg_rd;
        lo_addr = rg_rd; hi_addr = rg_rd;
      end
      StPop3: begin
        e_d = dir_q ? rh_rd : fh_rd;
        pt_d = pj;
      end
      StEdge: begin
        fe_addr = EA'(e_q - HB'(1)); re_addr = EA'(e_q - HB'(1));
      end
      StEdge2: begin
        j_d = tgt; e_d = lnk;
        wt_addr = tgt; lo_addr = tgt; hi_addr = tgt; qm_addr = tgt;
      end
      StEdge3: begin
        lo_addr = j_q; hi_addr = j_q; qm_addr = j_q;
        lo_wd = {1'b1, cand}; hi_wd = {1'b1, cand};
        if (better) begin
          lo_we = !dir_q; hi_we = dir_q;
          if (!qm_rd) begin
            rg_addr = back_q; rg_wd = j_q; rg_we = 1'b1;
            qm_wd = 1'b1; qm_we = 1'b1;
            back_d = ring_next(back_q);
          end
        end
      end
      StAns: ;
      StAns2: begin
        if (lo_rd[W] && hi_rd[W] && (hi_rd[W-1:0] > lo_rd[W-1:0]) &&
            ((hi_rd[W-1:0] - lo_rd[W-1:0]) > best_q)) begin
          best_d = hi_rd[W-1:0] - lo_rd[W-1:0];
        end
        ix_d = ix_q + VB'(1);
        if (ix_q == vc_idx) begin
          rsp_d.status = StatusOk;
          rsp_d.spread = 16'(best_d);
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClrAll;
      vc_q    <= 10'd1;
      done_q  <= 1'b0;
      ix_q    <= '0;
      used_q  <= '0;
      front_q <= '0;
      back_q  <= '0;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) vc_q <= cfg_data_i;
      done_q  <= done_d;
      ix_q    <= ix_d;
      used_q  <= used_d;
      front_q <= front_d;
      back_q  <= back_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    t_q    <= t_d;
    j_q    <= j_d;
    e_q    <= e_d;
    pt_q   <= pt_d;
    best_q <= best_d;
  end

  assign busy        = (state_q != StIdle);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = (state_q == StIdle);

  `BPMS_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "response strobe longer than one cycle")
  `BPMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted without going busy")
  `BPMS_ASSERT(a_used_bound, 32'(used_q) <= MaxEdges, "edge count beyond edge store")
  `BPMS_ASSERT(a_status_code, !done_o || (rsp_o.status != 2'd3), "undefined response status")

endmodule
